@@ sv/gpf_pkg.sv @@
// gpf_pkg: shared constants, types and helpers of the goldbach partition finder
`default_nettype none

package gpf_pkg;

  // sieve bound and field widths
  localparam int LIMIT   = 1048576;
  localparam int N_W     = 21;
  localparam int SP_W    = 20;
  localparam int LP_W    = 21;
  localparam int ST_W    = 2;

  localparam logic [31:0] LIMIT_U = 32'(LIMIT);

  // sieve counter widths: candidate multiples may run one step past the bound
  localparam int LIMIT_W = $clog2(LIMIT + 1);
  localparam int J_W     = LIMIT_W + 1;
  localparam int I_W     = (LIMIT_W + 1) / 2 + 1;

  // bitmap keeps odd numbers only, one bit per odd k at index k/2
  localparam int WORD_W  = 32;
  localparam int OFF_W   = $clog2(WORD_W);
  localparam int ODD_CNT = (LIMIT + 1) / 2;
  localparam int WORDS   = (ODD_CNT + WORD_W - 1) / WORD_W;
  localparam int ADDR_W  = (WORDS > 1) ? $clog2(WORDS) : 1;

  // result status codes
  localparam logic [ST_W-1:0] ST_FOUND = 2'd0;
  localparam logic [ST_W-1:0] ST_NONE  = 2'd1;
  localparam logic [ST_W-1:0] ST_BAD   = 2'd2;

  // one access on a bitmap port
  typedef struct packed {
    logic              en;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] wdata;
  } ram_req_t;

  // word address of an odd number
  function automatic logic [ADDR_W-1:0] word_of(input logic [J_W-1:0] k);
    return k[ADDR_W+OFF_W:OFF_W+1];
  endfunction

  // bit position of an odd number inside its word
  function automatic logic [OFF_W-1:0] off_of(input logic [J_W-1:0] k);
    return k[OFF_W:1];
  endfunction

endpackage

`default_nettype wire

@@ sv/goldbach_partition_finder_core.sv @@
// goldbach_partition_finder_core: top level, bitmap ram, sieve and search
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+---------------------------------------
//   in      | input     | in_valid / in_stall | even_value
//   out     | output    | out_valid/out_stall | status, value_echo, smaller_prime,
//           |           |                     | larger_prime
//
// after reset the sieve owns the bitmap: it fills the 32-bit words with ones (the bit of
// 1 cleared), then strikes each odd multiple by a read and a write back; in_stall stays
// high until it finishes. an item then tries odd candidates one per cycle over the two
// ram read ports, ending at the first partition or once the candidates pass half the
// value; an invalid item finishes without reads. a new beat is taken once the result
// sits in the output register, and a stalled result beat holds the search at its
// final step.
`default_nettype none

module goldbach_partition_finder_core import gpf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [N_W-1:0]   even_value,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [ST_W-1:0]  status,
  output logic [N_W-1:0]   value_echo,
  output logic [SP_W-1:0]  smaller_prime,
  output logic [LP_W-1:0]  larger_prime
);

  ram_req_t          sieve_req;
  ram_req_t          srch_req_a;
  ram_req_t          srch_req_b;
  ram_req_t          req_a;
  logic              sieve_done;
  logic [WORD_W-1:0] rdata_a;
  logic [WORD_W-1:0] rdata_b;

  // port a belongs to the sieve until the bitmap is complete
  assign req_a = sieve_done ? srch_req_a : sieve_req;

  gpf_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORDS)
  ) u_bitmap (
    .clk     (clk),
    .en_a    (req_a.en),
    .we_a    (req_a.we),
    .addr_a  (req_a.addr),
    .wdata_a (req_a.wdata),
    .rdata_a (rdata_a),
    .en_b    (srch_req_b.en),
    .addr_b  (srch_req_b.addr),
    .rdata_b (rdata_b)
  );

  gpf_sieve u_sieve (
    .clk   (clk),
    .rst   (rst),
    .rdata (rdata_a),
    .req   (sieve_req),
    .done  (sieve_done)
  );

  gpf_search u_search (
    .clk           (clk),
    .rst           (rst),
    .ready         (sieve_done),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .even_value    (even_value),
    .rdata_a       (rdata_a),
    .rdata_b       (rdata_b),
    .req_a         (srch_req_a),
    .req_b         (srch_req_b),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .value_echo    (value_echo),
    .smaller_prime (smaller_prime),
    .larger_prime  (larger_prime)
  );

`ifndef SYNTHESIS
  // no beat is taken while the sieve still owns the bitmap
  a_no_accept_in_sieve: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> sieve_done)
    else $error("input beat accepted before sieve finished");

  // no result can appear before the bitmap is complete
  a_no_result_in_sieve: assert property (@(posedge clk) disable iff (rst)
    !sieve_done |-> !out_valid)
    else $error("result beat during sieve");

  // a found partition sums to the echoed value
  a_found_sum: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_FOUND)) |->
      ((LP_W'(smaller_prime) + larger_prime) == value_echo))
    else $error("partition does not sum to input");

  // other outcomes carry zero primes
  a_other_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != ST_FOUND)) |->
      ((smaller_prime == '0) && (larger_prime == '0)))
    else $error("nonzero primes without a partition");
`endif

endmodule

`default_nettype wire

@@ sv/gpf_ram.sv @@
// gpf_ram: generic synchronous ram, one read/write port and one read port
`default_nettype none

module gpf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                    clk,
  input  logic                                    en_a,
  input  logic                                    we_a,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_a,
  input  logic [WIDTH-1:0]                        wdata_a,
  output logic [WIDTH-1:0]                        rdata_a,
  input  logic                                    en_b,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_b,
  output logic [WIDTH-1:0]                        rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // port a: write or registered read
  always_ff @(posedge clk) begin
    if (en_a) begin
      if (we_a) begin
        mem[addr_a] <= wdata_a;
      end else begin
        rdata_a <= mem[addr_a];
      end
    end
  end

  // port b: registered read
  always_ff @(posedge clk) begin
    if (en_b) begin
      rdata_b <= mem[addr_b];
    end
  end

endmodule

`default_nettype wire

@@ sv/gpf_sieve.sv @@
// gpf_sieve: fills the odd-number primality bitmap after reset
`default_nettype none

module gpf_sieve import gpf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [WORD_W-1:0] rdata,
  output ram_req_t          req,
  output logic              done
);

  typedef enum logic [2:0] {
    S_FILL,
    S_OUTER_RD,
    S_OUTER_CHK,
    S_INNER_RD,
    S_INNER_WR,
    S_DONE
  } state_t;

  localparam logic [WORD_W-1:0] FIRST_WORD = ~WORD_W'(1);

  state_t             state;
  logic [ADDR_W-1:0]  fill_addr;
  logic [I_W-1:0]     prime;
  logic [J_W-1:0]     mult;
  logic [2*I_W-1:0]   sq;
  logic [J_W-1:0]     step;
  logic [J_W-1:0]     prime_ext;

  // square and stride of the current prime
  always_comb begin
    sq        = {{I_W{1'b0}}, prime} * {{I_W{1'b0}}, prime};
    prime_ext = J_W'(prime);
    step      = prime_ext << 1;
  end

  assign done = (state == S_DONE);

  // sequencer: fill with ones (bit of 1 cleared), then strike odd multiples from p*p in steps of 2p
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_FILL;
      fill_addr <= '0;
      prime     <= I_W'(3);
      mult      <= '0;
    end else begin
      unique case (state)
        S_FILL: begin
          fill_addr <= fill_addr + 1'b1;
          if (fill_addr == ADDR_W'(WORDS - 1)) begin
            state <= S_OUTER_RD;
            prime <= I_W'(3);
          end
        end
        S_OUTER_RD: begin
          if (32'(sq) > LIMIT_U) begin
            state <= S_DONE;
          end else begin
            mult  <= J_W'(sq);
            state <= S_OUTER_CHK;
          end
        end
        S_OUTER_CHK: begin
          if (rdata[off_of(prime_ext)]) begin
            state <= S_INNER_RD;
          end else begin
            prime <= prime + I_W'(2);
            state <= S_OUTER_RD;
          end
        end
        S_INNER_RD: begin
          if (32'(mult) > LIMIT_U) begin
            prime <= prime + I_W'(2);
            state <= S_OUTER_RD;
          end else begin
            state <= S_INNER_WR;
          end
        end
        S_INNER_WR: begin
          mult  <= mult + step;
          state <= S_INNER_RD;
        end
        S_DONE: begin
          state <= S_DONE;
        end
        default: begin
          state <= S_FILL;
        end
      endcase
    end
  end

  // bitmap access for the current step
  always_comb begin
    req = '0;
    unique case (state)
      S_FILL: begin
        req.en    = 1'b1;
        req.we    = 1'b1;
        req.addr  = fill_addr;
        req.wdata = (fill_addr == '0) ? FIRST_WORD : '1;
      end
      S_OUTER_RD: begin
        req.en   = 1'b1;
        req.addr = word_of(prime_ext);
      end
      S_INNER_RD: begin
        req.en   = 1'b1;
        req.addr = word_of(mult);
      end
      S_INNER_WR: begin
        req.en    = 1'b1;
        req.we    = 1'b1;
        req.addr  = word_of(mult);
        req.wdata = rdata & ~(WORD_W'(1) << off_of(mult));
      end
      default: begin
        req = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ sv/gpf_search.sv @@
// gpf_search: walks odd candidates against the bitmap and holds the result beat
`default_nettype none

module gpf_search import gpf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              ready,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [N_W-1:0]    even_value,
  input  logic [WORD_W-1:0] rdata_a,
  input  logic [WORD_W-1:0] rdata_b,
  output ram_req_t          req_a,
  output ram_req_t          req_b,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ST_W-1:0]   status,
  output logic [N_W-1:0]    value_echo,
  output logic [SP_W-1:0]   smaller_prime,
  output logic [LP_W-1:0]   larger_prime
);

  logic             busy;
  logic [N_W-1:0]   n;
  logic             bad;
  logic [SP_W-1:0]  cand;
  logic             rd_vld;
  logic [SP_W-1:0]  rd_p;
  logic [OFF_W-1:0] rd_off_a;
  logic [OFF_W-1:0] rd_off_b;

  logic [SP_W-1:0]  half;
  logic [N_W-1:0]   partner;
  logic [N_W-1:0]   rd_partner;
  logic             found;
  logic             finish;
  logic             issue;
  logic             out_free;
  logic             in_take;
  logic             in_bad;

  // candidate step decisions
  always_comb begin
    half       = n[N_W-1:1];
    partner    = n - N_W'(cand);
    rd_partner = n - N_W'(rd_p);
    found      = rd_vld && rdata_a[rd_off_a] && rdata_b[rd_off_b];
    finish     = busy && (bad || found || (!rd_vld && (cand > half)));
    issue      = busy && !finish && (cand <= half);
    out_free   = !out_valid || !out_stall;
    in_take    = in_valid && !in_stall;
    in_bad     = even_value[0] || (even_value < N_W'(6)) ||
                 ({{(32-N_W){1'b0}}, even_value} > LIMIT_U);
  end

  assign in_stall = busy || !ready;

  // reads of p on port a and n-p on port b
  always_comb begin
    req_a       = '0;
    req_b       = '0;
    req_a.en    = issue;
    req_a.addr  = word_of(J_W'(cand));
    req_b.en    = issue;
    req_b.addr  = word_of(J_W'(partner));
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_take) begin
        busy <= 1'b1;
      end
      if (finish && out_free) begin
        out_valid <= 1'b1;
        busy      <= 1'b0;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (issue) begin
        rd_vld <= 1'b1;
      end else if (!finish) begin
        rd_vld <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      n    <= even_value;
      bad  <= in_bad;
      cand <= SP_W'(3);
    end
    if (issue) begin
      rd_p     <= cand;
      rd_off_a <= off_of(J_W'(cand));
      rd_off_b <= off_of(J_W'(partner));
      cand     <= cand + SP_W'(2);
    end
    if (finish && out_free) begin
      value_echo <= n;
      if (bad) begin
        status        <= ST_BAD;
        smaller_prime <= '0;
        larger_prime  <= '0;
      end else if (found) begin
        status        <= ST_FOUND;
        smaller_prime <= rd_p;
        larger_prime  <= LP_W'(rd_partner);
      end else begin
        status        <= ST_NONE;
        smaller_prime <= '0;
        larger_prime  <= '0;
      end
    end
  end

endmodule

`default_nettype wire
